// ===== sv/spwm_pkg.sv =====
package spwm_pkg;

  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned DUTY_W      = 16;
  localparam int unsigned MOD_W       = 13;
  localparam int unsigned MID_DUTY    = 16384;
  localparam int unsigned FULL_DUTY   = 32768;
  localparam int unsigned M_ONE       = 4096;
  localparam logic [31:0] TURN_THIRD  = 32'h5555_5555;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] STEP_PERIOD_RESET = 32'd214748;

  localparam logic [1:0] LANE_U = 2'd0;
  localparam logic [1:0] LANE_V = 2'd1;
  localparam logic [1:0] LANE_W = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] modulation;
    logic signed [31:0] frequency;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_u;
    logic [DUTY_W-1:0]  duty_v;
    logic [DUTY_W-1:0]  duty_w;
    logic [PHASE_W-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic             clear;
    logic [MOD_W-1:0] modulation;
    logic             freq_neg;
    logic [31:0]      freq_mag;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROM,
    ST_SCALE,
    ST_DUTY,
    ST_DONE
  } back_state_e;

  // quarter-wave sine entry, Taylor series to the x^17 term in Q30
  function automatic logic [31:0] quarter_sine(input logic [31:0] j,
                                               input int addr_bits,
                                               input int amp_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        peak;
    logic [63:0]        rounded;
    logic signed [63:0] sum;
    x    = ({32'b0, j} * {32'b0, HALF_PI_Q30}) >> (addr_bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        8: term = term / 64'd272;
        default: term = term;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    peak    = (64'd1 << (amp_bits - 1)) - 64'd1;
    rounded = (unsigned'(sum) * peak + (64'd1 << 29)) >> 30;
    return rounded[31:0];
  endfunction

endpackage

// ===== sv/spwm_front.sv =====
module spwm_front (
  input  spwm_pkg::in_item_t item_i,
  output spwm_pkg::cmd_t     cmd_o
);

  logic [15:0] mod_raw;

  assign mod_raw = unsigned'(item_i.modulation);

  always_comb begin
    cmd_o.clear    = item_i.mode;
    cmd_o.freq_neg = item_i.frequency[31];
    cmd_o.freq_mag = item_i.frequency[31] ? (32'd0 - unsigned'(item_i.frequency))
                                          : unsigned'(item_i.frequency);
    // clamp index to 0..1.0
    if (mod_raw[15]) begin
      cmd_o.modulation = '0;
    end else if (mod_raw > 16'(spwm_pkg::M_ONE)) begin
      cmd_o.modulation = spwm_pkg::MOD_W'(spwm_pkg::M_ONE);
    end else begin
      cmd_o.modulation = mod_raw[spwm_pkg::MOD_W-1:0];
    end
  end

endmodule

// ===== sv/spwm_fifo.sv =====
module spwm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  spwm_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output spwm_pkg::cmd_t rd_data_o,
  output logic           empty_o
);

  spwm_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_wr, do_rd;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/spwm_back.sv =====
module spwm_back #(
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned SINE_AMP_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         step_period_i,
  input  logic                cmd_empty_i,
  input  spwm_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output spwm_pkg::out_item_t result_o,
  output logic                empty_o,
  input  logic                pop_i
);

  localparam int unsigned QBITS = SINE_ADDR_BITS - 2;
  localparam int unsigned QLEN  = 1 << QBITS;
  localparam int unsigned IDX_W = QBITS + 1;
  localparam int unsigned ROM_W = SINE_AMP_BITS - 1;
  localparam int unsigned SH    = SINE_AMP_BITS - 3;
  localparam int unsigned NW    = SINE_AMP_BITS + 14;
  localparam int unsigned DW    = NW - SH;
  localparam logic [31:0] ADDR_ROUND = 32'd1 << (31 - SINE_ADDR_BITS);
  localparam logic signed [NW-1:0] BASE  = NW'(spwm_pkg::MID_DUTY) <<< SH;
  localparam logic signed [NW-1:0] ROUND = NW'(1) <<< (SH - 1);

  logic [ROM_W-1:0] qtab [QLEN+1];

  for (genvar g = 0; g <= QLEN; g++) begin : g_tab
    assign qtab[g] = ROM_W'(spwm_pkg::quarter_sine(32'(g), SINE_ADDR_BITS, SINE_AMP_BITS));
  end

  spwm_pkg::back_state_e state_q, state_d;
  spwm_pkg::cmd_t        cmd_q;
  logic [31:0]           phase_q;
  logic [63:0]           prod_q;
  logic [ROM_W-1:0]      rom_q;
  logic                  sneg_q;
  logic [1:0]            lane_q;
  logic [spwm_pkg::DUTY_W-1:0] duty_q [3];
  logic                  out_valid_q, out_valid_d;
  spwm_pkg::out_item_t   out_q;
  logic                  out_wr;

  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic [31:0]           incr, delta;
  logic [31:0]           lane_phase, addr_sum;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [IDX_W-1:0]      idx;
  logic signed [NW-1:0]  scaled, num;
  logic [DW-1:0]         dsh;
  logic [spwm_pkg::DUTY_W-1:0] duty_new;

  // shared multiplier: phase step, then the three duty products
  always_comb begin
    if (state_q == spwm_pkg::ST_MUL) begin
      mul_a = cmd_q.freq_mag;
      mul_b = step_period_i;
    end else begin
      mul_a = 32'(cmd_q.modulation);
      mul_b = 32'(rom_q);
    end
    mul_p = {32'b0, mul_a} * {32'b0, mul_b};
  end

  // floor toward minus infinity for a backward step
  always_comb begin
    incr  = prod_q[47:16] + 32'(cmd_q.freq_neg && (prod_q[15:0] != 16'd0));
    delta = cmd_q.freq_neg ? (32'd0 - incr) : incr;
  end

  always_comb begin
    case (lane_q)
      spwm_pkg::LANE_V: lane_phase = phase_q - spwm_pkg::TURN_THIRD;
      spwm_pkg::LANE_W: lane_phase = phase_q + spwm_pkg::TURN_THIRD;
      default:          lane_phase = phase_q;
    endcase
    addr_sum = lane_phase + ADDR_ROUND;
    addr     = addr_sum[31 -: SINE_ADDR_BITS];
    idx      = addr[QBITS] ? (IDX_W'(QLEN) - {1'b0, addr[QBITS-1:0]})
                           : {1'b0, addr[QBITS-1:0]};
  end

  always_comb begin
    scaled = signed'({1'b0, prod_q[NW-2:0]});
    if (sneg_q) begin
      scaled = -scaled;
    end
    num = BASE + scaled + ROUND;
    dsh = unsigned'(num[NW-1:SH]);
    if (num < 0) begin
      duty_new = '0;
    end else if (dsh > DW'(spwm_pkg::FULL_DUTY)) begin
      duty_new = spwm_pkg::DUTY_W'(spwm_pkg::FULL_DUTY);
    end else begin
      duty_new = dsh[spwm_pkg::DUTY_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    out_wr    = 1'b0;
    case (state_q)
      spwm_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = cmd_i.clear ? spwm_pkg::ST_DONE : spwm_pkg::ST_MUL;
        end
      end
      spwm_pkg::ST_MUL:   state_d = spwm_pkg::ST_ACC;
      spwm_pkg::ST_ACC:   state_d = spwm_pkg::ST_ROM;
      spwm_pkg::ST_ROM:   state_d = spwm_pkg::ST_SCALE;
      spwm_pkg::ST_SCALE: state_d = spwm_pkg::ST_DUTY;
      spwm_pkg::ST_DUTY: begin
        state_d = (lane_q == spwm_pkg::LANE_W) ? spwm_pkg::ST_DONE : spwm_pkg::ST_ROM;
      end
      spwm_pkg::ST_DONE: begin
        if (!out_valid_q || pop_i) begin
          out_wr  = 1'b1;
          state_d = spwm_pkg::ST_IDLE;
        end
      end
      default: state_d = spwm_pkg::ST_IDLE;
    endcase
    if (out_wr) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spwm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      lane_q      <= spwm_pkg::LANE_U;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        spwm_pkg::ST_IDLE: begin
          if (cmd_pop_o && cmd_i.clear) begin
            phase_q <= '0;
          end
        end
        spwm_pkg::ST_ACC: begin
          phase_q <= phase_q + delta;
          lane_q  <= spwm_pkg::LANE_U;
        end
        spwm_pkg::ST_DUTY: lane_q <= lane_q + 2'd1;
        default: lane_q <= lane_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      spwm_pkg::ST_IDLE: begin
        cmd_q <= cmd_i;
        for (int k = 0; k < 3; k++) begin
          duty_q[k] <= spwm_pkg::DUTY_W'(spwm_pkg::MID_DUTY);
        end
      end
      spwm_pkg::ST_MUL:   prod_q <= mul_p;
      spwm_pkg::ST_ROM: begin
        rom_q  <= qtab[idx];
        sneg_q <= addr[QBITS+1];
      end
      spwm_pkg::ST_SCALE: prod_q <= mul_p;
      spwm_pkg::ST_DUTY:  duty_q[lane_q] <= duty_new;
      default: prod_q <= prod_q;
    endcase
    if (out_wr) begin
      out_q.duty_u <= duty_q[0];
      out_q.duty_v <= duty_q[1];
      out_q.duty_w <= duty_q[2];
      out_q.phase  <= phase_q;
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

endmodule

// ===== sv/three_phase_spwm_generator.sv =====
// Channel  | Direction | Handshake                 | Beat
// ---------+-----------+---------------------------+----------------------------------
// item     | in        | push, full                | mode, modulation, frequency
// result   | out       | empty, pop                | duty_u, duty_v, duty_w, phase
// config   | in        | cfg_valid_i, cfg_ready_o  | step_period
//
// An advancing beat in the back end does one multiply for the phase
// step, then ROM read, multiply and round for each of the three phases in turn on
// the one shared multiplier. A clearing beat skips these steps.
// Reset clears the phase and loads the default step period; the ROM needs no fill.
// A two-entry command queue takes beats while the back end works or the result
// waits to be popped.
module three_phase_spwm_generator #(
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned SINE_AMP_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  spwm_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output spwm_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic [31:0]    step_period_q;
  spwm_pkg::cmd_t front_cmd;
  spwm_pkg::cmd_t queue_cmd;
  logic           queue_empty;
  logic           queue_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= spwm_pkg::STEP_PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      step_period_q <= cfg_data_i;
    end
  end

  spwm_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  spwm_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (queue_pop),
    .rd_data_o (queue_cmd),
    .empty_o   (queue_empty)
  );

  spwm_back #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SINE_AMP_BITS  (SINE_AMP_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_period_i (step_period_q),
    .cmd_empty_i   (queue_empty),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (queue_pop),
    .result_o      (result_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule
